@@ hdl/palette_color_indexer_assert.svh @@
// Assertion macros shared by the palette colour indexer RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef PALETTE_COLOR_INDEXER_ASSERT_SVH
`define PALETTE_COLOR_INDEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCI_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pci_pkg.sv @@
// Package for the palette colour indexer: sizes, codes and payload types.
// Used by every module of the block; depends on nothing.
package pci_pkg;

   // Palette size and the widths that follow from it.
   localparam int PALETTE_DEPTH = 256;
   localparam int IDX_W         = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int CAM_SLOTS     = 1 << IDX_W;

   // Fixed field widths.
   localparam int ENTRY_W  = 32;
   localparam int COLOR_W  = 8;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 3;

   // Entry layout is R, G, B, A from the top byte down.
   localparam logic [ENTRY_W-1:0] RGB_MASK     = 32'hFFFF_FF00;
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'h00;

   // Item modes.
   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_PRELOAD = 2'd1;
   localparam logic [1:0] MODE_PIXEL   = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PARTIAL = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_STICKY  = 3'd4;

   // Sticky error codes.
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_ALPHA = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   // Output format register values.
   localparam logic FMT_RAW = 1'b0;
   localparam logic FMT_PNG = 1'b1;

   // Register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FORMAT = 1'b0;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] alpha;
      logic               end_of_image;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  color_index;
      logic [STATUS_W-1:0] status;
      logic                is_new_entry;
      logic                is_transparent;
      logic [COUNT_W-1:0]  entry_count;
      logic                alpha_seen;
      logic                last_out;
   } rsp_type;

   // Lookup key towards the palette store.
   typedef struct packed {
      logic [ENTRY_W-1:0] key;
      logic               rgb_only;
   } cam_key_type;

   // Append port of the palette store.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0] wr_data;
   } cam_wr_type;

   // Lowest matching entry.
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
   } cam_hit_type;

endpackage

@@ hdl/palette_color_indexer.sv @@
// Palette colour indexer. Each request transaction (clear, preload, pixel or unused mode)
// gives exactly one response transaction. The block takes one transaction per clock cycle
// while the response register is free or draining. A request accepted into the request
// register is matched against every palette entry at once by a combinational compare, and
// its response is then captured in the response register. The rate is set by that
// parallel compare and lowest-index tree over all 256 entries, which also lets each pixel
// see the entry appended by the one just before it. While a valid response waits on
// rsp_ready the response register holds. One further request can still be taken into the
// request register, after which req_ready stays low until the response drains. There is no
// clearing pass after reset; the user writes format_select over the APB port only while no
// transaction is in flight, and the block itself does not enforce this.

// Top level of the palette colour indexer: handshake registers, decision logic and state.
// Depends on pci_pkg, pci_csr, pci_cam and palette_color_indexer_assert.svh.
`include "palette_color_indexer_assert.svh"

module palette_color_indexer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pci_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pci_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pci_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pci_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pci_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int CntW = pci_pkg::CNT_W;
   localparam int IdxW = pci_pkg::IDX_W;

   logic                  format_select;
   logic                  in_valid_ff, in_valid_in;
   pci_pkg::req_type      in_data_ff, in_data_in;
   logic                  out_valid_ff, out_valid_in;
   pci_pkg::rsp_type      out_data_ff, out_data_in;
   logic [CntW-1:0]       total_ff, total_in;
   logic                  alpha_ff, alpha_in;
   logic [1:0]            err_ff, err_in;
   logic                  fire;
   logic                  full;
   logic                  partial;
   logic [pci_pkg::ENTRY_W-1:0] rgb;
   pci_pkg::cam_key_type  lookup;
   pci_pkg::cam_wr_type   wr;
   pci_pkg::cam_hit_type  match;
   logic [IdxW-1:0]       index;
   logic [pci_pkg::STATUS_W-1:0] status;
   logic                  is_new;
   logic                  transp;

   pci_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .format_select (format_select)
   );

   pci_cam u_cam (
      .clock       (clock),
      .lookup      (lookup),
      .entry_total (total_ff),
      .wr          (wr),
      .result      (match)
   );

   // The held request is processed when the response register is free or draining.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Lookup key built from the held request.
   assign rgb = {in_data_ff.red, in_data_ff.green, in_data_ff.blue, 8'h00};
   assign lookup.key      = rgb | {24'h0, in_data_ff.alpha};
   assign lookup.rgb_only = (format_select == pci_pkg::FMT_RAW);

   assign full    = (total_ff >= CntW'(pci_pkg::PALETTE_DEPTH));
   assign partial = (in_data_ff.alpha != pci_pkg::ALPHA_CLEAR) &&
                    (in_data_ff.alpha != pci_pkg::ALPHA_OPAQUE);

   // Decision for one transaction: index, status and the state that follows.
   always_comb begin
      index      = '0;
      status     = pci_pkg::STATUS_OK;
      is_new     = 1'b0;
      transp     = 1'b0;
      total_in   = total_ff;
      alpha_in   = alpha_ff;
      err_in     = err_ff;
      wr.wr_en   = 1'b0;
      wr.wr_addr = total_ff[IdxW-1:0];
      wr.wr_data = rgb | {24'h0, pci_pkg::ALPHA_OPAQUE};
      unique case (in_data_ff.mode)
         pci_pkg::MODE_CLEAR: begin
            total_in = '0;
            alpha_in = 1'b0;
            err_in   = pci_pkg::ERR_NONE;
         end
         pci_pkg::MODE_PRELOAD: begin
            if (err_ff != pci_pkg::ERR_NONE) begin
               status = pci_pkg::STATUS_STICKY;
            end else if ((format_select == pci_pkg::FMT_PNG) || full) begin
               status = pci_pkg::STATUS_IGNORED;
            end else begin
               index    = total_ff[IdxW-1:0];
               is_new   = 1'b1;
               wr.wr_en = 1'b1;
               total_in = total_ff + CntW'(1);
            end
         end
         pci_pkg::MODE_PIXEL: begin
            if (err_ff != pci_pkg::ERR_NONE) begin
               status = pci_pkg::STATUS_STICKY;
            end else if ((format_select == pci_pkg::FMT_RAW) &&
                         (in_data_ff.alpha == pci_pkg::ALPHA_CLEAR)) begin
               transp   = 1'b1;
               alpha_in = 1'b1;
            end else if ((format_select == pci_pkg::FMT_RAW) && partial) begin
               status = pci_pkg::STATUS_PARTIAL;
               err_in = pci_pkg::ERR_ALPHA;
            end else if (match.hit) begin
               index = match.index;
            end else if (full) begin
               status = pci_pkg::STATUS_FULL;
               err_in = pci_pkg::ERR_FULL;
            end else begin
               index    = total_ff[IdxW-1:0];
               is_new   = 1'b1;
               wr.wr_en = 1'b1;
               total_in = total_ff + CntW'(1);
               if (format_select == pci_pkg::FMT_PNG) begin
                  wr.wr_data = lookup.key;
                  if (in_data_ff.alpha != pci_pkg::ALPHA_OPAQUE) begin
                     alpha_in = 1'b1;
                  end
               end
            end
         end
         pci_pkg::MODE_UNUSED: begin
            status = pci_pkg::STATUS_IGNORED;
         end
         default: begin
            status = pci_pkg::STATUS_IGNORED;
         end
      endcase
      if (!fire) begin
         wr.wr_en = 1'b0;
         total_in = total_ff;
         alpha_in = alpha_ff;
         err_in   = err_ff;
      end
   end

   // Response register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (fire) begin
         out_valid_in               = 1'b1;
         out_data_in.color_index    = pci_pkg::INDEX_W'(index);
         out_data_in.status         = status;
         out_data_in.is_new_entry   = is_new;
         out_data_in.is_transparent = transp;
         out_data_in.entry_count    = pci_pkg::COUNT_W'(total_in);
         out_data_in.alpha_seen     = alpha_in;
         out_data_in.last_out       = in_data_ff.end_of_image;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
         alpha_ff     <= 1'b0;
         err_ff       <= pci_pkg::ERR_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         total_ff     <= total_in;
         alpha_ff     <= alpha_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks on the fill level, the append path and the match tree.
   `PCI_ASSERT_SAME(a_count_bound, 1'b1, total_ff <= CntW'(pci_pkg::PALETTE_DEPTH),
                    "palette count beyond depth")
   `PCI_ASSERT_NEXT(a_append_step, fire && is_new, total_ff == $past(total_ff) + CntW'(1),
                    "append did not advance the count")
   `PCI_ASSERT_SAME(a_sticky_blocks,
                    fire && (err_ff != pci_pkg::ERR_NONE) &&
                    (in_data_ff.mode != pci_pkg::MODE_CLEAR),
                    !wr.wr_en, "append under a sticky error")
   `PCI_ASSERT_SAME(a_hit_in_range, in_valid_ff && match.hit,
                    CntW'(match.index) < total_ff, "match beyond the filled entries")

endmodule

@@ hdl/pci_csr.sv @@
// Register block of the palette colour indexer: APB-style access to format_select.
// Depends on pci_pkg.
module pci_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pci_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pci_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pci_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic                             format_select
);

   logic format_ff;
   logic format_in;
   logic wr_strobe;

   // The register sits at byte address zero; bit two selects the word.
   assign wr_strobe = psel && penable && pwrite;

   always_comb begin
      format_in = format_ff;
      if (wr_strobe && (paddr[2] == pci_pkg::REG_FORMAT)) begin
         format_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= pci_pkg::FMT_RAW;
      end else begin
         format_ff <= format_in;
      end
   end

   // Reads return the register, and zero for words beyond it.
   always_comb begin
      prdata = '0;
      if (paddr[2] == pci_pkg::REG_FORMAT) begin
         prdata = {{(pci_pkg::CSR_DATA_W-1){1'b0}}, format_ff};
      end
   end

   assign pready        = 1'b1;
   assign format_select = format_ff;

endmodule

@@ hdl/pci_cam.sv @@
// Palette store of the indexer: one row of entries with a comparator each and a
// lowest-index match tree. Depends on pci_pkg.
module pci_cam (
   input  logic                      clock,
   input  pci_pkg::cam_key_type      lookup,
   input  logic [pci_pkg::CNT_W-1:0] entry_total,
   input  pci_pkg::cam_wr_type       wr,
   output pci_pkg::cam_hit_type      result
);

   localparam int Depth = pci_pkg::PALETTE_DEPTH;
   localparam int Slots = pci_pkg::CAM_SLOTS;
   localparam int IdxW  = pci_pkg::IDX_W;

   logic [pci_pkg::ENTRY_W-1:0] entry_ff [0:Depth-1];
   logic [pci_pkg::ENTRY_W-1:0] cmp_mask;
   logic [Slots-1:0]            match_vec;
   logic                        tree_hit [0:IdxW][0:Slots-1];
   logic [IdxW-1:0]             tree_idx [0:IdxW][0:Slots-1];

   // Entries are appended one at a time at the current fill level.
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         entry_ff[wr.wr_addr] <= wr.wr_data;
      end
   end

   // Raw format ignores the alpha byte when matching.
   assign cmp_mask = lookup.rgb_only ? pci_pkg::RGB_MASK : '1;

   // Every filled entry compares against the key in parallel.
   for (genvar g = 0; g < Slots; g++) begin : g_cell
      if (g < Depth) begin : g_used
         assign match_vec[g] = (pci_pkg::CNT_W'(g) < entry_total) &&
                               (((entry_ff[g] ^ lookup.key) & cmp_mask) == '0);
      end else begin : g_pad
         assign match_vec[g] = 1'b0;
      end
   end

   // Binary tree that keeps the lower-indexed hit at each node.
   always_comb begin
      for (int l = 0; l <= IdxW; l++) begin
         for (int n = 0; n < Slots; n++) begin
            tree_hit[l][n] = 1'b0;
            tree_idx[l][n] = '0;
         end
      end
      for (int n = 0; n < Slots; n++) begin
         tree_hit[0][n] = match_vec[n];
         tree_idx[0][n] = IdxW'(n);
      end
      for (int l = 1; l <= IdxW; l++) begin
         for (int n = 0; n < (Slots >> l); n++) begin
            tree_hit[l][n] = tree_hit[l-1][2*n] | tree_hit[l-1][2*n+1];
            tree_idx[l][n] = tree_hit[l-1][2*n] ? tree_idx[l-1][2*n]
                                                : tree_idx[l-1][2*n+1];
         end
      end
   end

   assign result.hit   = tree_hit[IdxW][0];
   assign result.index = tree_idx[IdxW][0];

endmodule
